// ----- sv/heater_pid_regulator_top_assert.svh -----
// Assertion macros for the heater PID regulator.
`ifndef HEATER_PID_REGULATOR_TOP_ASSERT_SVH
`define HEATER_PID_REGULATOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define HPR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define HPR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/htr_pid_pkg.sv -----
// Types, constants and control program for the heater PID regulator.
package htr_pid_pkg;

	localparam int ACC_W  = 28;
	localparam int PROD_W = 34;
	localparam int DVD_W  = 20;
	localparam int DIV_BITS = 4;
	localparam int DIV_ITER = DVD_W / DIV_BITS;

	localparam int INT_WINDOW = 30;
	localparam int LOG_B1 = 81;
	localparam int LOG_B2 = 9;
	localparam int LOG_B3 = 3;

	localparam logic [10:0] MIN_TEMP_RST = 11'h700;
	localparam logic [10:0] MAX_TEMP_RST = 11'h3FF;

	localparam logic [2:0] REG_TARGET = 3'd0;
	localparam logic [2:0] REG_KP     = 3'd1;
	localparam logic [2:0] REG_KI     = 3'd2;
	localparam logic [2:0] REG_KD     = 3'd3;
	localparam logic [2:0] REG_FF     = 3'd4;
	localparam logic [2:0] REG_ILIM   = 3'd5;
	localparam logic [2:0] REG_MIN    = 3'd6;
	localparam logic [2:0] REG_MAX    = 3'd7;

	localparam logic [3:0] STEP_IDLE     = 4'd0;
	localparam logic [3:0] STEP_CHK      = 4'd1;
	localparam logic [3:0] STEP_MUL_P    = 4'd2;
	localparam logic [3:0] STEP_ADD_P    = 4'd3;
	localparam logic [3:0] STEP_INT      = 4'd4;
	localparam logic [3:0] STEP_MUL_I    = 4'd5;
	localparam logic [3:0] STEP_ADD_I    = 4'd6;
	localparam logic [3:0] STEP_MUL_D    = 4'd7;
	localparam logic [3:0] STEP_DIV_INIT = 4'd8;
	localparam logic [3:0] STEP_DIV      = 4'd9;
	localparam logic [3:0] STEP_ADD_D    = 4'd10;
	localparam logic [3:0] STEP_OUT      = 4'd11;
	localparam logic [3:0] STEP_END      = 4'd12;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_CHK,
		OP_MUL_KP,
		OP_MUL_KI,
		OP_MUL_KD,
		OP_ADD_PROD,
		OP_INT,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_ADD_QUOT,
		OP_OUT,
		OP_NOP
	} uop_t;

	typedef enum logic [2:0] {
		COND_NONE,
		COND_NO_INPUT,
		COND_ERR_GE30,
		COND_DIV_MORE,
		COND_OUT_BUSY,
		COND_ALWAYS
	} ucond_t;

	typedef struct packed {
		uop_t       op;
		ucond_t     cond;
		logic [3:0] target;
	} uword_t;

	function automatic uword_t ucode_rom(input logic [3:0] step);
		uword_t w;
		case (step)
			STEP_IDLE:     w = '{OP_IDLE,     COND_NO_INPUT, STEP_IDLE};
			STEP_CHK:      w = '{OP_CHK,      COND_NONE,     STEP_IDLE};
			STEP_MUL_P:    w = '{OP_MUL_KP,   COND_NONE,     STEP_IDLE};
			STEP_ADD_P:    w = '{OP_ADD_PROD, COND_NONE,     STEP_IDLE};
			STEP_INT:      w = '{OP_INT,      COND_ERR_GE30, STEP_MUL_D};
			STEP_MUL_I:    w = '{OP_MUL_KI,   COND_NONE,     STEP_IDLE};
			STEP_ADD_I:    w = '{OP_ADD_PROD, COND_NONE,     STEP_IDLE};
			STEP_MUL_D:    w = '{OP_MUL_KD,   COND_NONE,     STEP_IDLE};
			STEP_DIV_INIT: w = '{OP_DIV_INIT, COND_NONE,     STEP_IDLE};
			STEP_DIV:      w = '{OP_DIV_STEP, COND_DIV_MORE, STEP_DIV};
			STEP_ADD_D:    w = '{OP_ADD_QUOT, COND_NONE,     STEP_IDLE};
			STEP_OUT:      w = '{OP_OUT,      COND_OUT_BUSY, STEP_OUT};
			STEP_END:      w = '{OP_NOP,      COND_ALWAYS,   STEP_IDLE};
			default:       w = '{OP_NOP,      COND_ALWAYS,   STEP_IDLE};
		endcase
		return w;
	endfunction

	// Coarse base-3 log of |error|, plus one.
	function automatic logic [3:0] log_div(input logic [10:0] mag);
		logic [11:0] m;
		logic a, b, c;
		m = {1'b0, mag};
		a = m > 12'(LOG_B1);
		if (a) begin
			b = m >= 12'(LOG_B1 * (LOG_B2 + 1));
			if (b) begin
				c = m >= 12'(LOG_B1 * LOG_B2 * (LOG_B3 + 1));
			end else begin
				c = m >= 12'(LOG_B1 * (LOG_B3 + 1));
			end
		end else begin
			b = m > 12'(LOG_B2);
			if (b) begin
				c = m >= 12'(LOG_B2 * (LOG_B3 + 1));
			end else begin
				c = m > 12'(LOG_B3);
			end
		end
		return 4'd1 + {1'b0, a, 2'b00} + {2'b00, b, 1'b0} + {3'b000, c};
	endfunction

endpackage

// ----- sv/heater_pid_regulator_top.sv -----
// Heater PID regulator with feedforward, microcoded sequencer.
//
//  channel   direction  handshake             payload
//  in        sink       in_valid / in_stall   temp_sample
//  out       source     out_valid / out_stall duty, drive, over_temp, under_temp
//  cfg       APB slave  psel/penable/pready   paddr, pwdata, prdata
//
// The integral term is skipped when the error is 30 or more; a new sample is taken only
// once the program is back in idle, not while one is still in work.
// One control word per step, with the D-term divider looping five times (4 quotient
// bits each). The 17x17 multiplier is shared by the P, I and D terms.
// Reset clears sequencer, cutoff latch and loop state, and presets the cfg registers.
// in_stall is high while a sample is in work; a held result blocks only STEP_OUT.
`include "heater_pid_regulator_top_assert.svh"

module heater_pid_regulator_top
	import htr_pid_pkg::*;
#(
	parameter int DUTY_MAX = 255
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [10:0] temp_sample,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         duty,
	output logic [7:0]         drive,
	output logic               over_temp,
	output logic               under_temp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam logic [7:0] DMAX = 8'(DUTY_MAX);
	localparam logic [2:0] DIV_LAST = 3'(DIV_ITER - 1);

	logic [9:0]         target_q;
	logic [15:0]        kp_q, ki_q, kd_q;
	logic [7:0]         ff_q;
	logic [14:0]        ilim_q;
	logic signed [10:0] min_q, max_q;

	logic signed [10:0] last_q;
	logic signed [15:0] isum_q;
	logic               cutoff_q;

	logic [3:0]         step_q, step_d;
	uword_t             uw;
	logic               jump;

	logic signed [10:0] t_q;
	logic signed [11:0] err_q, dlt_q;
	logic [3:0]         g_q;
	logic               over_q, under_q, tgt_nz_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [DVD_W-1:0]   dvd_q;
	logic [3:0]         rem_q;
	logic               neg_q;
	logic [2:0]         div_cnt_q;

	logic               out_valid_q, over_out_q, under_out_q;
	logic [7:0]         duty_q, drive_q;

	logic               cfg_wr;
	logic [2:0]         cfg_idx;

	logic               chk_over, chk_under, chk_cut;
	logic [9:0]         chk_tgt;
	logic [7:0]         chk_ff;
	logic signed [11:0] chk_err, chk_dlt;
	logic [10:0]        chk_mag;

	logic [15:0]        mul_gain;
	logic signed [16:0] mul_a, mul_b;
	logic signed [PROD_W-1:0] prod_d;
	logic signed [PROD_W-1:0] prod_adj, prod_sh;
	logic [PROD_W-1:0]  prod_abs;

	logic               err_ge30;
	logic signed [16:0] int_sum, int_lim, int_clamp;

	logic [3:0]         div_rem_d;
	logic [DVD_W-1:0]   div_quo_d;
	logic signed [ACC_W-1:0] quot_s;

	logic [7:0]         duty_d;
	logic               out_busy;

	// config port
	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr  = psel & penable & pwrite;

	always_comb begin
		case (cfg_idx)
			REG_TARGET: prdata = {22'd0, target_q};
			REG_KP:     prdata = {16'd0, kp_q};
			REG_KI:     prdata = {16'd0, ki_q};
			REG_KD:     prdata = {16'd0, kd_q};
			REG_FF:     prdata = {24'd0, ff_q};
			REG_ILIM:   prdata = {17'd0, ilim_q};
			REG_MIN:    prdata = {21'd0, min_q};
			REG_MAX:    prdata = {21'd0, max_q};
			default:    prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			kp_q     <= '0;
			ki_q     <= '0;
			kd_q     <= '0;
			ff_q     <= '0;
			ilim_q   <= '0;
			min_q    <= MIN_TEMP_RST;
			max_q    <= MAX_TEMP_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_TARGET: target_q <= pwdata[9:0];
				REG_KP:     kp_q     <= pwdata[15:0];
				REG_KI:     ki_q     <= pwdata[15:0];
				REG_KD:     kd_q     <= pwdata[15:0];
				REG_FF:     ff_q     <= pwdata[7:0];
				REG_ILIM:   ilim_q   <= pwdata[14:0];
				REG_MIN:    min_q    <= pwdata[10:0];
				REG_MAX:    max_q    <= pwdata[10:0];
				default:    ;
			endcase
		end
	end

	// sequencer
	assign uw       = ucode_rom(step_q);
	assign in_stall = (step_q != STEP_IDLE);
	assign out_busy = out_valid_q & out_stall;
	assign err_ge30 = err_q >= $signed(12'(INT_WINDOW));

	always_comb begin
		case (uw.cond)
			COND_NONE:     jump = 1'b0;
			COND_NO_INPUT: jump = !in_valid;
			COND_ERR_GE30: jump = err_ge30;
			COND_DIV_MORE: jump = (div_cnt_q != DIV_LAST);
			COND_OUT_BUSY: jump = out_busy;
			COND_ALWAYS:   jump = 1'b1;
			default:       jump = 1'b1;
		endcase
	end

	always_comb begin
		if (jump) begin
			step_d = uw.target;
		end else begin
			step_d = step_q + 4'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	// window check and error terms
	assign chk_over  = t_q >= max_q;
	assign chk_under = t_q <= min_q;
	assign chk_cut   = cutoff_q | chk_over | chk_under;
	assign chk_tgt   = chk_cut ? 10'd0 : target_q;
	assign chk_ff    = chk_cut ? 8'd0 : ((ff_q < DMAX) ? ff_q : DMAX);
	assign chk_err   = $signed({2'b00, chk_tgt}) - 12'(t_q);
	assign chk_dlt   = 12'(t_q) - 12'(last_q);
	assign chk_mag   = chk_err[11] ? 11'(-chk_err) : chk_err[10:0];

	// shared multiplier
	always_comb begin
		case (uw.op)
			OP_MUL_KP: begin
				mul_gain = kp_q;
				mul_b    = 17'(err_q);
			end
			OP_MUL_KI: begin
				mul_gain = ki_q;
				mul_b    = 17'(isum_q);
			end
			OP_MUL_KD: begin
				mul_gain = kd_q;
				mul_b    = 17'(dlt_q);
			end
			default: begin
				mul_gain = 16'd0;
				mul_b    = 17'sd0;
			end
		endcase
	end

	assign mul_a  = $signed({1'b0, mul_gain});
	assign prod_d = mul_a * mul_b;

	// product / 256 toward zero
	assign prod_adj = prod_q + $signed({{(PROD_W - 8){1'b0}}, {8{prod_q[PROD_W-1]}}});
	assign prod_sh  = prod_adj >>> 8;
	assign prod_abs = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);

	// integral accumulate and clamp
	assign int_sum = 17'(isum_q) + 17'(err_q);
	assign int_lim = $signed({2'b00, ilim_q});
	always_comb begin
		if (int_sum > int_lim) begin
			int_clamp = int_lim;
		end else if (int_sum < -int_lim) begin
			int_clamp = -int_lim;
		end else begin
			int_clamp = int_sum;
		end
	end

	// restoring divide, several quotient bits per step
	always_comb begin
		div_rem_d = rem_q;
		div_quo_d = dvd_q;
		for (int i = 0; i < DIV_BITS; i++) begin
			div_rem_d = {div_rem_d[2:0], div_quo_d[DVD_W-1]};
			div_quo_d = {div_quo_d[DVD_W-2:0], 1'b0};
			if (div_rem_d >= g_q) begin
				div_rem_d    = div_rem_d - g_q;
				div_quo_d[0] = 1'b1;
			end
		end
	end

	assign quot_s = neg_q ? -$signed({{(ACC_W - DVD_W){1'b0}}, dvd_q})
	                      :  $signed({{(ACC_W - DVD_W){1'b0}}, dvd_q});

	always_comb begin
		if (acc_q < 0) begin
			duty_d = 8'd0;
		end else if (acc_q > $signed({{(ACC_W - 8){1'b0}}, DMAX})) begin
			duty_d = DMAX;
		end else begin
			duty_d = acc_q[7:0];
		end
	end

	// datapath payload
	always_ff @(posedge clk) begin
		case (uw.op)
			OP_IDLE: begin
				if (in_valid) begin
					t_q <= temp_sample;
				end
			end
			OP_CHK: begin
				err_q    <= chk_err;
				dlt_q    <= chk_dlt;
				g_q      <= log_div(chk_mag);
				over_q   <= chk_over;
				under_q  <= chk_under;
				tgt_nz_q <= (chk_tgt != 10'd0);
				acc_q    <= $signed({{(ACC_W - 8){1'b0}}, chk_ff});
			end
			OP_MUL_KP, OP_MUL_KI, OP_MUL_KD: begin
				prod_q <= prod_d;
			end
			OP_ADD_PROD: begin
				acc_q <= acc_q + ACC_W'(prod_sh);
			end
			OP_DIV_INIT: begin
				dvd_q <= prod_abs[DVD_W+7:8];
				neg_q <= prod_q[PROD_W-1];
				rem_q <= 4'd0;
			end
			OP_DIV_STEP: begin
				dvd_q <= div_quo_d;
				rem_q <= div_rem_d;
			end
			OP_ADD_QUOT: begin
				acc_q <= acc_q + quot_s;
			end
			OP_OUT: begin
				if (!out_busy) begin
					duty_q      <= duty_d;
					drive_q     <= tgt_nz_q ? duty_d : 8'd0;
					over_out_q  <= over_q;
					under_out_q <= under_q;
				end
			end
			default: ;
		endcase
	end

	// loop state and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q      <= '0;
			isum_q      <= '0;
			cutoff_q    <= 1'b0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr && cfg_idx == REG_TARGET) begin
				cutoff_q <= 1'b0;
			end else if (uw.op == OP_CHK) begin
				cutoff_q <= chk_cut;
			end
			if (uw.op == OP_CHK) begin
				last_q <= t_q;
			end
			if (uw.op == OP_INT && !err_ge30) begin
				isum_q <= 16'(int_clamp);
			end
			if (uw.op == OP_DIV_INIT) begin
				div_cnt_q <= '0;
			end else if (uw.op == OP_DIV_STEP) begin
				div_cnt_q <= div_cnt_q + 3'd1;
			end
			if (uw.op == OP_OUT && !out_busy) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign duty       = duty_q;
	assign drive      = drive_q;
	assign over_temp  = over_out_q;
	assign under_temp = under_out_q;

	`HPR_ASSERT_NXT(a_accept_starts_chk, in_valid && !in_stall, step_q == STEP_CHK, "transfer did not start the program")
	`HPR_ASSERT_IMP(a_duty_max, out_valid, duty <= DMAX, "duty above maximum")
	`HPR_ASSERT_IMP(a_drive_duty, out_valid, drive == duty || drive == 8'd0, "drive neither duty nor zero")
	`HPR_ASSERT_NXT(a_int_clamp, uw.op == OP_INT && !err_ge30, isum_q <= int_lim && isum_q >= -int_lim, "integral beyond limit")
	`HPR_ASSERT_NXT(a_div_rem, uw.op == OP_DIV_STEP, rem_q < g_q, "divider remainder not below divisor")

endmodule
